// ===== sv/ucfp_pkg.sv =====
// Package for the command frame processor: character codes, status and
// state types, request struct and small decimal helper functions.
// No dependencies.
package ucfp_pkg;

  localparam int unsigned RX_DEPTH = 32;
  localparam int unsigned ADDR_W   = $clog2(RX_DEPTH);
  localparam int unsigned CNT_W    = $clog2(RX_DEPTH + 1);

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_UC_D  = 8'h44;
  localparam logic [7:0] CH_UC_E  = 8'h45;
  localparam logic [7:0] CH_UC_M  = 8'h4D;
  localparam logic [7:0] CH_UC_S  = 8'h53;
  localparam logic [7:0] CH_UC_V  = 8'h56;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  localparam logic [3:0] NEED_SHORT = 4'd5;
  localparam logic [3:0] NEED_M     = 4'd8;
  localparam logic [3:0] NEED_S     = 4'd10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FRAMING  = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_CMD,
    C_CHK,
    C_SCAN,
    C_DRAIN,
    C_EVAL
  } ctrl_state_e;

  typedef enum logic [1:0] {
    R_IDLE,
    R_PREP,
    R_SUM,
    R_SEND
  } rep_state_e;

  typedef struct packed {
    logic              valid;
    logic              temp;
    logic [7:0]        letter;
    status_e           status;
    logic signed [7:0] value;
    logic signed [7:0] desired;
    logic              verbose;
  } rep_req_t;

  typedef struct packed {
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] ack_code(status_e st);
    logic [7:0] code;
    unique case (st)
      ST_OK:       code = CH_LC_O;
      ST_FRAMING:  code = CH_LC_F;
      ST_CHECKSUM: code = CH_LC_S;
      default:     code = CH_LC_I;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] div10(logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return 4'(p >> 11);
  endfunction

  function automatic digits_t dec_digits(logic [7:0] v);
    digits_t    r;
    logic [7:0] rem8;
    logic [6:0] rem;
    if (v >= 8'd200) begin
      r.d2 = 4'd2;
      rem8 = v - 8'd200;
    end else if (v >= 8'd100) begin
      r.d2 = 4'd1;
      rem8 = v - 8'd100;
    end else begin
      r.d2 = 4'd0;
      rem8 = v;
    end
    rem  = rem8[6:0];
    r.d1 = div10(rem);
    r.d0 = 4'(rem - 7'(r.d1) * 7'd10);
    return r;
  endfunction

endpackage

// ===== sv/ucfp_rx_if.sv =====
// Receive channel: valid/ready handshake with byte and temperature sample.
// No dependencies.
interface ucfp_rx_if;
  logic              valid;
  logic              ready;
  logic [7:0]        rx_byte;
  logic signed [7:0] current_temp;

  modport source (output valid, output rx_byte, output current_temp, input ready);
  modport sink   (input valid, input rx_byte, input current_temp, output ready);
endinterface

// ===== sv/ucfp_tx_if.sv =====
// Reply channel: valid/ready handshake with reply byte and status fields.
// No dependencies.
interface ucfp_tx_if;
  logic              valid;
  logic              ready;
  logic [7:0]        tx_byte;
  logic              last;
  logic [1:0]        status;
  logic signed [7:0] desired_level;
  logic              verbose_flag;

  modport source (output valid, output tx_byte, output last, output status,
                  output desired_level, output verbose_flag, input ready);
  modport sink   (input valid, input tx_byte, input last, input status,
                  input desired_level, input verbose_flag, output ready);
endinterface

// ===== sv/ucfp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ucfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/ucfp_reply.sv =====
// Reply sequencer: builds an acknowledge or temperature reply frame and
// emits it one byte per item through an output register. Uses ucfp_pkg.
module ucfp_reply (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ucfp_pkg::rep_req_t req_i,
  output logic              busy_o,
  ucfp_tx_if.source         tx
);
  import ucfp_pkg::*;

  rep_state_e        st_q, st_d;
  logic              temp_q, temp_d;
  logic [7:0]        letter_q, letter_d;
  status_e           status_q, status_d;
  logic signed [7:0] value_q, value_d;
  logic signed [7:0] desired_q, desired_d;
  logic              verbose_q, verbose_d;
  logic [7:0]        sign_q, sign_d;
  logic [7:0]        hi_q, hi_d;
  logic [7:0]        lo_q, lo_d;
  digits_t           ck_q, ck_d;
  logic [3:0]        pos_q, pos_d;
  logic              out_v_q, out_v_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [1:0]        out_status_q, out_status_d;
  logic signed [7:0] out_des_q, out_des_d;
  logic              out_verb_q, out_verb_d;

  logic [7:0] mag;
  logic [6:0] sat;
  logic [3:0] hi_val;
  logic [7:0] sum8;
  logic [3:0] len_m1;
  logic [7:0] cur_byte;

  assign mag    = value_q[7] ? 8'(-value_q) : 8'(value_q);
  assign sat    = (mag > 8'd99) ? 7'd99 : mag[6:0];
  assign hi_val = div10(sat);
  assign sum8   = temp_q ? 8'(letter_q + CH_LC_T + sign_q + hi_q + lo_q)
                         : 8'(CH_UC_E + ack_code(status_q));
  assign len_m1 = temp_q ? 4'd9 : 4'd6;

  always_comb begin
    cur_byte = CH_BANG;
    if (temp_q) begin
      case (pos_q)
        4'd0:    cur_byte = CH_HASH;
        4'd1:    cur_byte = letter_q;
        4'd2:    cur_byte = CH_LC_T;
        4'd3:    cur_byte = sign_q;
        4'd4:    cur_byte = hi_q;
        4'd5:    cur_byte = lo_q;
        4'd6:    cur_byte = CH_ZERO + 8'(ck_q.d2);
        4'd7:    cur_byte = CH_ZERO + 8'(ck_q.d1);
        4'd8:    cur_byte = CH_ZERO + 8'(ck_q.d0);
        default: cur_byte = CH_BANG;
      endcase
    end else begin
      case (pos_q)
        4'd0:    cur_byte = CH_HASH;
        4'd1:    cur_byte = CH_UC_E;
        4'd2:    cur_byte = ack_code(status_q);
        4'd3:    cur_byte = CH_ZERO + 8'(ck_q.d2);
        4'd4:    cur_byte = CH_ZERO + 8'(ck_q.d1);
        4'd5:    cur_byte = CH_ZERO + 8'(ck_q.d0);
        default: cur_byte = CH_BANG;
      endcase
    end
  end

  always_comb begin
    st_d         = st_q;
    temp_d       = temp_q;
    letter_d     = letter_q;
    status_d     = status_q;
    value_d      = value_q;
    desired_d    = desired_q;
    verbose_d    = verbose_q;
    sign_d       = sign_q;
    hi_d         = hi_q;
    lo_d         = lo_q;
    ck_d         = ck_q;
    pos_d        = pos_q;
    out_v_d      = out_v_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    out_des_d    = out_des_q;
    out_verb_d   = out_verb_q;

    if (out_v_q && tx.ready) begin
      out_v_d = 1'b0;
    end

    unique case (st_q)
      R_IDLE: begin
        if (req_i.valid) begin
          temp_d    = req_i.temp;
          letter_d  = req_i.letter;
          status_d  = req_i.status;
          value_d   = req_i.value;
          desired_d = req_i.desired;
          verbose_d = req_i.verbose;
          st_d      = R_PREP;
        end
      end
      R_PREP: begin
        sign_d = value_q[7] ? CH_MINUS : CH_PLUS;
        hi_d   = CH_ZERO + 8'(hi_val);
        lo_d   = CH_ZERO + 8'(sat - 7'(hi_val) * 7'd10);
        st_d   = R_SUM;
      end
      R_SUM: begin
        ck_d  = dec_digits(sum8);
        pos_d = '0;
        st_d  = R_SEND;
      end
      R_SEND: begin
        if (!out_v_q || tx.ready) begin
          out_v_d      = 1'b1;
          out_byte_d   = cur_byte;
          out_last_d   = (pos_q == len_m1);
          out_status_d = status_q;
          out_des_d    = desired_q;
          out_verb_d   = verbose_q;
          pos_d        = pos_q + 4'd1;
          if (pos_q == len_m1) begin
            st_d = R_IDLE;
          end
        end
      end
      default: st_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= R_IDLE;
      out_v_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      st_q    <= st_d;
      out_v_q <= out_v_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q       <= temp_d;
    letter_q     <= letter_d;
    status_q     <= status_d;
    value_q      <= value_d;
    desired_q    <= desired_d;
    verbose_q    <= verbose_d;
    sign_q       <= sign_d;
    hi_q         <= hi_d;
    lo_q         <= lo_d;
    ck_q         <= ck_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
    out_des_q    <= out_des_d;
    out_verb_q   <= out_verb_d;
  end

  assign busy_o           = (st_q != R_IDLE) || out_v_q;
  assign tx.valid         = out_v_q;
  assign tx.tx_byte       = out_byte_q;
  assign tx.last          = out_last_q;
  assign tx.status        = out_status_q;
  assign tx.desired_level = out_des_q;
  assign tx.verbose_flag  = out_verb_q;

  a_req_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> (st_q == R_IDLE) && !out_v_q)
    else $error("reply request while sequencer busy");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == R_SEND) |-> (pos_q <= len_m1))
    else $error("reply position beyond frame length");

  a_last_ends_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_last_q) |-> (st_q != R_SEND))
    else $error("closing byte out while still sending");

endmodule

// ===== sv/uart_command_frame_processor_top.sv =====
// Top level of the command frame processor: receive store in RAM, frame
// checker sequencer, reply sequencer. Uses ucfp_pkg, ucfp_ram, ucfp_reply.
//
//   channel | dir | handshake       | payload
//   rx      | in  | valid/ready     | rx_byte, current_temp
//   tx      | out | valid/ready     | tx_byte, last, status, desired_level, verbose_flag
//
// A '!' that closes a frame of the right length reads the store (need-1 reads on
// one RAM read port); the reply sequencer then prepares the reply in its R_PREP and
// R_SUM states and sends it as 7 or 10 reply items.
// rx.ready stays low from a '!' that draws a reply until the whole reply has been taken.
// Reset clears the fill count, start flag, desired level and verbose mode;
// the store needs no clearing pass. A stalled tx holds the reply.
module uart_command_frame_processor_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ucfp_rx_if.sink   rx,
  ucfp_tx_if.source tx
);
  import ucfp_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              seen_q, seen_d;
  logic [ADDR_W-1:0] spos_q, spos_d;
  logic [ADDR_W-1:0] fs_q, fs_d;
  logic [CNT_W-1:0]  end_q, end_d;
  logic signed [7:0] temp_q, temp_d;
  logic signed [7:0] desired_q, desired_d;
  logic              verbose_q, verbose_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [3:0]        need_q, need_d;
  logic [3:0]        iss_q, iss_d;
  logic              pend_v_q, pend_v_d;
  logic [3:0]        pend_off_q, pend_off_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        dig2_q, dig2_d;
  logic [7:0]        dig1_q, dig1_d;
  logic [7:0]        dig0_q, dig0_d;
  logic [7:0]        sgn_q, sgn_d;
  logic [7:0]        m1_q, m1_d;
  logic [7:0]        m0_q, m0_d;

  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              rep_busy;
  rep_req_t          rep_req;
  logic [3:0]        need_dec;
  logic [9:0]        ck_val;
  logic [6:0]        m_val;
  logic              ck_ok;
  logic              m_ok;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = (state_q == C_IDLE) && !rep_busy;
  assign ram_we   = accept && (fill_q < CNT_W'(RX_DEPTH));

  assign ck_val = 10'(dig2_q[3:0]) * 10'd100 + 10'(dig1_q[3:0]) * 10'd10
                + 10'(dig0_q[3:0]);
  assign ck_ok  = is_digit(dig2_q) && is_digit(dig1_q) && is_digit(dig0_q)
                && (ck_val == {2'b00, sum_q});
  assign m_val  = 7'(m1_q[3:0]) * 7'd10 + 7'(m0_q[3:0]);
  assign m_ok   = is_digit(m1_q) && is_digit(m0_q);

  always_comb begin
    unique case (ram_rdata)
      CH_UC_C, CH_UC_D, CH_UC_V: need_dec = NEED_SHORT;
      CH_UC_M:                   need_dec = NEED_M;
      CH_UC_S:                   need_dec = NEED_S;
      default:                   need_dec = '0;
    endcase
  end

  ucfp_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (rx.rx_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ucfp_reply u_reply (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rep_req),
    .busy_o (rep_busy),
    .tx     (tx)
  );

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    seen_d     = seen_q;
    spos_d     = spos_q;
    fs_d       = fs_q;
    end_d      = end_q;
    temp_d     = temp_q;
    desired_d  = desired_q;
    verbose_d  = verbose_q;
    cmd_d      = cmd_q;
    need_d     = need_q;
    iss_d      = iss_q;
    pend_v_d   = 1'b0;
    pend_off_d = pend_off_q;
    sum_d      = sum_q;
    dig2_d     = dig2_q;
    dig1_d     = dig1_q;
    dig0_d     = dig0_q;
    sgn_d      = sgn_q;
    m1_d       = m1_q;
    m0_d       = m0_q;
    ram_raddr  = fs_q + ADDR_W'(iss_q);
    rep_req    = '0;

    if (pend_v_q) begin
      if (pend_off_q <= need_q - 4'd4) begin
        sum_d = sum_q + ram_rdata;
      end
      if (pend_off_q == need_q - 4'd3) dig2_d = ram_rdata;
      if (pend_off_q == need_q - 4'd2) dig1_d = ram_rdata;
      if (pend_off_q == need_q - 4'd1) dig0_d = ram_rdata;
      if (pend_off_q == 4'd2) sgn_d = ram_rdata;
      if (pend_off_q == 4'd3) m1_d = ram_rdata;
      if (pend_off_q == 4'd4) m0_d = ram_rdata;
    end

    unique case (state_q)
      C_IDLE: begin
        if (accept) begin
          if (fill_q < CNT_W'(RX_DEPTH)) begin
            fill_d = fill_q + CNT_W'(1);
            if ((rx.rx_byte == CH_HASH) && !seen_q) begin
              seen_d = 1'b1;
              spos_d = fill_q[ADDR_W-1:0];
            end
          end
          if (rx.rx_byte == CH_BANG) begin
            fill_d = '0;
            seen_d = 1'b0;
            spos_d = '0;
            fs_d   = spos_q;
            end_d  = fill_q;
            temp_d = rx.current_temp;
            if (seen_q && (CNT_W'(spos_q) < fill_q)) begin
              if (CNT_W'(spos_q) + CNT_W'(1) == fill_q) begin
                rep_req.valid  = 1'b1;
                rep_req.status = ST_INVALID;
              end else begin
                state_d = C_CMD;
              end
            end
          end
        end
      end
      C_CMD: begin
        ram_raddr = fs_q + ADDR_W'(1);
        state_d   = C_CHK;
      end
      C_CHK: begin
        cmd_d  = ram_rdata;
        need_d = need_dec;
        if (need_dec == '0) begin
          rep_req.valid  = 1'b1;
          rep_req.status = ST_INVALID;
          state_d        = C_IDLE;
        end else if ((end_q - CNT_W'(fs_q)) != CNT_W'(need_dec)) begin
          rep_req.valid  = 1'b1;
          rep_req.status = ST_FRAMING;
          state_d        = C_IDLE;
        end else begin
          sum_d   = ram_rdata;
          iss_d   = 4'd2;
          state_d = C_SCAN;
        end
      end
      C_SCAN: begin
        pend_v_d   = 1'b1;
        pend_off_d = iss_q;
        iss_d      = iss_q + 4'd1;
        if (iss_q == need_q - 4'd1) begin
          state_d = C_DRAIN;
        end
      end
      C_DRAIN: begin
        state_d = C_EVAL;
      end
      C_EVAL: begin
        rep_req.valid  = 1'b1;
        rep_req.status = ST_OK;
        state_d        = C_IDLE;
        if (!ck_ok) begin
          rep_req.status = ST_CHECKSUM;
        end else begin
          unique case (cmd_q)
            CH_UC_C: begin
              rep_req.temp   = 1'b1;
              rep_req.letter = CH_LC_C;
              rep_req.value  = temp_q;
            end
            CH_UC_D: begin
              rep_req.temp   = 1'b1;
              rep_req.letter = CH_LC_D;
              rep_req.value  = desired_q;
            end
            CH_UC_M: begin
              if (m_ok) begin
                desired_d = (sgn_q == CH_MINUS) ? -$signed({1'b0, m_val})
                                                : $signed({1'b0, m_val});
              end else begin
                rep_req.status = ST_INVALID;
              end
            end
            CH_UC_V: verbose_d = !verbose_q;
            default: rep_req.status = ST_OK;
          endcase
        end
      end
      default: state_d = C_IDLE;
    endcase

    rep_req.desired = desired_d;
    rep_req.verbose = verbose_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      fill_q    <= '0;
      seen_q    <= 1'b0;
      spos_q    <= '0;
      desired_q <= '0;
      verbose_q <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      seen_q    <= seen_d;
      spos_q    <= spos_d;
      desired_q <= desired_d;
      verbose_q <= verbose_d;
      pend_v_q  <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fs_q       <= fs_d;
    end_q      <= end_d;
    temp_q     <= temp_d;
    cmd_q      <= cmd_d;
    need_q     <= need_d;
    iss_q      <= iss_d;
    pend_off_q <= pend_off_d;
    sum_q      <= sum_d;
    dig2_q     <= dig2_d;
    dig1_q     <= dig1_d;
    dig0_q     <= dig0_d;
    sgn_q      <= sgn_d;
    m1_q       <= m1_d;
    m0_q       <= m0_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(RX_DEPTH))
    else $error("fill count beyond store depth");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (rx.rx_byte == CH_BANG)) |=> (fill_q == '0) && !seen_q)
    else $error("store not cleared after frame end");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_SCAN) |-> (iss_q < need_q) && (CNT_W'(fs_q) + CNT_W'(iss_q) < end_q))
    else $error("store read beyond frame");

endmodule
